// ----- hw/rtl/choice_rotate_stream_cipher_macros.svh -----
// Assertion helpers shared by the cipher RTL. They vanish in synthesis.
`ifndef CHOICE_ROTATE_STREAM_CIPHER_MACROS_SVH
`define CHOICE_ROTATE_STREAM_CIPHER_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the condition.
`define CRSC_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
// The consequent must hold in the cycle after the condition.
`define CRSC_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define CRSC_ASSERT_NOW(label, clk, rst_n, cond, expr, msg)
`define CRSC_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)
`endif
`endif

// ----- hw/rtl/crsc_pkg.sv -----
package crsc_pkg;

    localparam int WORD_W      = 64;
    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = 5;
    localparam int ROT_W       = 6;
    localparam int CFG_IDX_W   = 3;

    typedef logic [WORD_W-1:0]             word_t;
    typedef word_t [3:0]                   quad_t;
    typedef word_t [TABLE_DEPTH-1:0]       table_t;
    typedef logic [IDX_W-1:0]              rc_idx_t;

    typedef enum logic
    {
        CMD_CONST = 1'b0,
        CMD_TEXT  = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_KEY_WORD_0   = 3'd0,
        REG_KEY_WORD_1   = 3'd1,
        REG_KEY_WORD_2   = 3'd2,
        REG_KEY_WORD_3   = 3'd3,
        REG_NONCE_WORD_0 = 3'd4,
        REG_NONCE_WORD_1 = 3'd5,
        REG_NONCE_WORD_2 = 3'd6,
        REG_NONCE_WORD_3 = 3'd7
    } cfg_reg_t;

    // Offsets XORed with the round number to pick the constant for each word.
    localparam logic [3:0][IDX_W-1:0] RC_OFS_S = {5'd13, 5'd7, 5'd5, 5'd3};
    localparam logic [3:0][IDX_W-1:0] RC_OFS_K = {5'd29, 5'd23, 5'd19, 5'd17};

    // Left rotations of the mixing steps, one per state word.
    localparam logic [3:0][ROT_W-1:0] ROT_S = {6'd13, 6'd7, 6'd5, 6'd3};
    localparam logic [3:0][ROT_W-1:0] ROT_K = {6'd29, 6'd23, 6'd19, 6'd17};

    typedef struct packed
    {
        logic    step;
        logic    first;
        logic    const_we;
        rc_idx_t const_idx;
    } core_ctrl_t;

    // Bitwise choice between x and y under sel, then a fixed non-zero rotation.
    function automatic word_t mix(word_t sel, word_t x, word_t y, logic [ROT_W-1:0] rot);
        word_t c;
        c = y ^ (sel & (x ^ y));
        return (c << rot) | (c >> (7'd64 - {1'b0, rot}));
    endfunction

endpackage

// ----- hw/rtl/crsc_item_if.sv -----
interface crsc_item_if;
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic                 first_word;
    crsc_pkg::rc_idx_t    constant_index;
    crsc_pkg::word_t      value;

    modport source (output valid, command, first_word, constant_index, value, input ready);
    modport sink   (input valid, command, first_word, constant_index, value, output ready);
endinterface

// ----- hw/rtl/crsc_result_if.sv -----
interface crsc_result_if;
    logic            valid;
    logic            ready;
    crsc_pkg::word_t text_out;

    modport source (output valid, text_out, input ready);
    modport sink   (input valid, text_out, output ready);
endinterface

// ----- hw/rtl/crsc_cfg_if.sv -----
interface crsc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [crsc_pkg::CFG_IDX_W-1:0]      index;
    crsc_pkg::word_t                     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/crsc_round.sv -----
module crsc_round #(
    parameter int ROUND_INDEX = 0
) (
    input  crsc_pkg::quad_t  s_in,
    input  crsc_pkg::quad_t  k_in,
    input  crsc_pkg::table_t rc_table,
    output crsc_pkg::quad_t  s_out,
    output crsc_pkg::quad_t  k_out
);

    localparam crsc_pkg::rc_idx_t RND = crsc_pkg::rc_idx_t'(ROUND_INDEX);

    crsc_pkg::quad_t s_inj;
    crsc_pkg::quad_t k_inj;

    // Constant and key injection; the key words used are those from before this round.
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            s_inj[j] = s_in[j] ^ k_in[j] ^ rc_table[RND ^ crsc_pkg::RC_OFS_S[j]];
            k_inj[j] = k_in[j] ^ rc_table[RND ^ crsc_pkg::RC_OFS_K[j]];
        end
    end

    // Each mixing step sees the words already updated earlier in the round.
    always_comb
    begin
        s_out[0] = s_inj[0] ^ crsc_pkg::mix(s_inj[1], s_inj[2], s_inj[3], crsc_pkg::ROT_S[0]);
        s_out[1] = s_inj[1] ^ crsc_pkg::mix(s_inj[2], s_inj[3], s_out[0], crsc_pkg::ROT_S[1]);
        s_out[2] = s_inj[2] ^ crsc_pkg::mix(s_inj[3], s_out[0], s_out[1], crsc_pkg::ROT_S[2]);
        s_out[3] = s_inj[3] ^ crsc_pkg::mix(s_out[0], s_out[1], s_out[2], crsc_pkg::ROT_S[3]);

        k_out[0] = k_inj[0] ^ crsc_pkg::mix(k_inj[1], k_inj[2], k_inj[3], crsc_pkg::ROT_K[0]);
        k_out[1] = k_inj[1] ^ crsc_pkg::mix(k_inj[2], k_inj[3], k_out[0], crsc_pkg::ROT_K[1]);
        k_out[2] = k_inj[2] ^ crsc_pkg::mix(k_inj[3], k_out[0], k_out[1], crsc_pkg::ROT_K[2]);
        k_out[3] = k_inj[3] ^ crsc_pkg::mix(k_out[0], k_out[1], k_out[2], crsc_pkg::ROT_K[3]);
    end

endmodule

// ----- hw/rtl/crsc_core.sv -----
`include "choice_rotate_stream_cipher_macros.svh"

module crsc_core #(
    parameter int ROUND_COUNT = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  crsc_pkg::core_ctrl_t ctrl,
    input  crsc_pkg::word_t      const_data,
    input  crsc_pkg::quad_t      key,
    input  crsc_pkg::quad_t      nonce,
    output crsc_pkg::word_t      keystream
);

    crsc_pkg::quad_t  s_reg;
    crsc_pkg::quad_t  s_next;
    crsc_pkg::quad_t  k_reg;
    crsc_pkg::quad_t  k_next;
    logic [1:0]       pos_reg;
    logic [1:0]       pos_next;
    crsc_pkg::table_t rc_table_reg;

    crsc_pkg::quad_t  s_start;
    crsc_pkg::quad_t  k_start;
    logic [1:0]       pos_cur;
    crsc_pkg::quad_t  s_chain [ROUND_COUNT+1];
    crsc_pkg::quad_t  k_chain [ROUND_COUNT+1];

    // A first word restarts from the nonce and key before anything else.
    assign s_start = ctrl.first ? nonce : s_reg;
    assign k_start = ctrl.first ? key : k_reg;
    assign pos_cur = ctrl.first ? 2'd0 : pos_reg;

    assign s_chain[0] = s_start;
    assign k_chain[0] = k_start;

    for (genvar g = 0; g < ROUND_COUNT; g++)
    begin : g_round
        crsc_round #(
            .ROUND_INDEX (g)
        ) u_round (
            .s_in     (s_chain[g]),
            .k_in     (k_chain[g]),
            .rc_table (rc_table_reg),
            .s_out    (s_chain[g+1]),
            .k_out    (k_chain[g+1])
        );
    end

    // A new block is made only at word position zero.
    always_comb
    begin
        if (pos_cur == 2'd0)
        begin
            s_next = s_chain[ROUND_COUNT] ^ k_chain[ROUND_COUNT];
            k_next = k_chain[ROUND_COUNT];
        end
        else
        begin
            s_next = s_start;
            k_next = k_start;
        end
        pos_next = pos_cur + 2'd1;
    end

    assign keystream = s_next[pos_cur];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg   <= '0;
            k_reg   <= '0;
            pos_reg <= 2'd0;
        end
        else if (ctrl.step)
        begin
            s_reg   <= s_next;
            k_reg   <= k_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.const_we)
        begin
            rc_table_reg[ctrl.const_idx] <= const_data;
        end
    end

    `CRSC_ASSERT_NEXT(a_first_pos, clk, rst_n, ctrl.step && ctrl.first, pos_reg == 2'd1, "first word did not leave position one")
    `CRSC_ASSERT_NEXT(a_pos_adv, clk, rst_n, ctrl.step && !ctrl.first, pos_reg == $past(pos_reg) + 2'd1, "word position did not advance by one")
    `CRSC_ASSERT_NEXT(a_hold, clk, rst_n, !ctrl.step, $stable(pos_reg) && $stable(s_reg) && $stable(k_reg), "cipher state changed without a text request")

endmodule

// ----- hw/rtl/choice_rotate_stream_cipher.sv -----
// A text request is held in the item registers, then its result in the result data register.
// Throughput: one request per cycle, text or constant, with no gaps at block boundaries, while text results are taken.
// The clock is set by the unrolled rounds of block generation, which run in one register stage.
// Reset clears the cipher and key state, the word position, the key and nonce registers and
// the handshake valids; the round-constant table must be written before it is used.
`include "choice_rotate_stream_cipher_macros.svh"

module choice_rotate_stream_cipher #(
    parameter int ROUND_COUNT = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    crsc_item_if.sink    item,
    crsc_result_if.source result,
    crsc_cfg_if.sink     cfg
);

    crsc_pkg::quad_t      key_reg;
    crsc_pkg::quad_t      nonce_reg;

    logic                 item_valid_reg;
    crsc_pkg::cmd_t       item_cmd_reg;
    logic                 item_first_reg;
    crsc_pkg::rc_idx_t    item_idx_reg;
    crsc_pkg::word_t      item_value_reg;

    logic                 result_valid_reg;
    logic                 result_valid_next;
    crsc_pkg::word_t      result_data_reg;

    logic                 advance;
    logic                 is_text;
    crsc_pkg::core_ctrl_t ctrl;
    crsc_pkg::word_t      keystream;

    assign is_text = (item_cmd_reg == crsc_pkg::CMD_TEXT);

    // A constant write never waits on the result side.
    assign advance    = item_valid_reg && (!is_text || !result_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    assign ctrl.step      = advance && is_text;
    assign ctrl.first     = item_first_reg;
    assign ctrl.const_we  = advance && !is_text;
    assign ctrl.const_idx = item_idx_reg;

    crsc_core #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .const_data (item_value_reg),
        .key        (key_reg),
        .nonce      (nonce_reg),
        .keystream  (keystream)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            nonce_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (crsc_pkg::cfg_reg_t'(cfg.index))
                crsc_pkg::REG_KEY_WORD_0:   key_reg[0]   <= cfg.data;
                crsc_pkg::REG_KEY_WORD_1:   key_reg[1]   <= cfg.data;
                crsc_pkg::REG_KEY_WORD_2:   key_reg[2]   <= cfg.data;
                crsc_pkg::REG_KEY_WORD_3:   key_reg[3]   <= cfg.data;
                crsc_pkg::REG_NONCE_WORD_0: nonce_reg[0] <= cfg.data;
                crsc_pkg::REG_NONCE_WORD_1: nonce_reg[1] <= cfg.data;
                crsc_pkg::REG_NONCE_WORD_2: nonce_reg[2] <= cfg.data;
                crsc_pkg::REG_NONCE_WORD_3: nonce_reg[3] <= cfg.data;
                default:                    key_reg      <= key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            item_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_cmd_reg   <= crsc_pkg::cmd_t'(item.command);
            item_first_reg <= item.first_word;
            item_idx_reg   <= item.constant_index;
            item_value_reg <= item.value;
        end
    end

    always_comb
    begin
        if (ctrl.step)
        begin
            result_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            result_data_reg <= item_value_reg ^ keystream;
        end
    end

    assign result.valid    = result_valid_reg;
    assign result.text_out = result_data_reg;

    `CRSC_ASSERT_NOW(a_ready_full, clk, rst_n, !item.ready, item_valid_reg && is_text && result_valid_reg, "input stalled without a blocked text request")
    `CRSC_ASSERT_NEXT(a_hold_item, clk, rst_n, item_valid_reg && !advance, item_valid_reg && $stable(item_value_reg) && $stable(item_cmd_reg), "held request was overwritten")
    `CRSC_ASSERT_NEXT(a_const_silent, clk, rst_n, item_valid_reg && !is_text && !result_valid_reg, !result_valid_reg, "constant write produced a result")

endmodule
